// ----- hdl/vector3_normalize_top_assert.svh -----
// Assertion macros for the vector normalizer checker.
// Needs clock and reset visible at the point of use.
`ifndef VECTOR3_NORMALIZE_TOP_ASSERT_SVH
`define VECTOR3_NORMALIZE_TOP_ASSERT_SVH
`define VN_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("vector normalizer check failed");
`define VN_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vector normalizer check failed");
`endif

// ----- hdl/vn_pkg.sv -----
// Shared constants and types for the vector normalizer pipeline.
// No dependencies.
`default_nettype none
package vn_pkg;
   localparam int FIELD_W   = 24;
   localparam int FRAC_BITS = 16;
   localparam int SUM_W     = 2 * FIELD_W;
   localparam int ROOT_W    = FIELD_W;
   localparam int REM_W     = ROOT_W + 3;
   localparam int DREM_W    = FIELD_W + 1;
   localparam int QUO_W     = FRAC_BITS + 1;
   localparam logic [FIELD_W-1:0] MIN_MAG_RESET = FIELD_W'(1);

   typedef struct packed {
      logic [2:0][FIELD_W-1:0] raw;
      logic [2:0][FIELD_W-1:0] mag_abs;
   } item_type;

   typedef struct packed {
      logic [SUM_W-1:0]  n;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [ROOT_W-1:0]        mag;
      logic                     too_small;
      logic [2:0][DREM_W-1:0]   rem;
      logic [2:0][QUO_W-1:0]    quo;
   } div_type;
endpackage
`default_nettype wire

// ----- hdl/vn_sqrt_step.sv -----
// One digit of the pipelined square root: one root bit per stage.
// Uses vn_pkg.
`default_nettype none
module vn_sqrt_step (
   input  vn_pkg::sqrt_type s_in,
   output vn_pkg::sqrt_type s_out
);
   logic [vn_pkg::REM_W-1:0] rem_sh;
   logic [vn_pkg::REM_W-1:0] trial;
   logic                     take;

   always_comb begin
      rem_sh = {s_in.rem[vn_pkg::REM_W-3:0], s_in.n[vn_pkg::SUM_W-1 -: 2]};
      trial  = vn_pkg::REM_W'({s_in.root, 2'b01});
      take   = rem_sh >= trial;
      s_out.n    = {s_in.n[vn_pkg::SUM_W-3:0], 2'b00};
      s_out.rem  = take ? rem_sh - trial : rem_sh;
      s_out.root = {s_in.root[vn_pkg::ROOT_W-2:0], take};
   end
endmodule
`default_nettype wire

// ----- hdl/vn_div_step.sv -----
// One quotient bit of the three-lane restoring divider.
// Uses vn_pkg.
`default_nettype none
module vn_div_step (
   input  vn_pkg::div_type d_in,
   output vn_pkg::div_type d_out
);
   logic [vn_pkg::DREM_W-1:0] dvs;
   logic [vn_pkg::DREM_W-1:0] diff;
   logic                      ge;

   always_comb begin
      d_out = d_in;
      dvs   = vn_pkg::DREM_W'(d_in.mag);
      for (int i = 0; i < 3; i++) begin
         ge   = d_in.rem[i] >= dvs;
         diff = ge ? d_in.rem[i] - dvs : d_in.rem[i];
         d_out.rem[i] = {diff[vn_pkg::DREM_W-2:0], 1'b0};
         d_out.quo[i] = {d_in.quo[i][vn_pkg::QUO_W-2:0], ge};
      end
   end
endmodule
`default_nettype wire

// ----- hdl/vector3_normalize_top.sv -----
// Top level of the vector normalizer: squares, sum, root and divider pipeline.
// Uses vn_pkg, vn_sqrt_step, vn_div_step.
//
//  channel | ports                           | handshake
//  request | req_in_x/y/z                    | start, busy
//  result  | rsp_out_x/y/z, rsp_magnitude,   | rsp_valid strobe, no back pressure
//          | rsp_too_small                   |
//  csr     | csr_min_magnitude               | csr_valid, csr_ready
//
// One vector enters every cycle; busy stays low and the receiver cannot stall.
// From the accepting edge to the edge that takes the result, the stages are:
// input, square, sum, root load, 24 root stages, compare, 17 divide stages, output.
// The root and divider chains set the depth.
// Reset clears the valid bits and sets min magnitude to 1.
`default_nettype none
module vector3_normalize_top (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire  signed [vn_pkg::FIELD_W-1:0] req_in_x,
   input  wire  signed [vn_pkg::FIELD_W-1:0] req_in_y,
   input  wire  signed [vn_pkg::FIELD_W-1:0] req_in_z,
   output logic                             rsp_valid,
   output logic signed [vn_pkg::FIELD_W-1:0] rsp_out_x,
   output logic signed [vn_pkg::FIELD_W-1:0] rsp_out_y,
   output logic signed [vn_pkg::FIELD_W-1:0] rsp_out_z,
   output logic        [vn_pkg::FIELD_W-1:0] rsp_magnitude,
   output logic                             rsp_too_small,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire         [vn_pkg::FIELD_W-1:0] csr_min_magnitude
);
   localparam int RW = vn_pkg::ROOT_W;
   localparam int QW = vn_pkg::QUO_W;
   localparam int FW = vn_pkg::FIELD_W;

   logic [FW-1:0] min_mag_ff;

   logic                      v0_ff, v1_ff, v2_ff, vo_ff;
   vn_pkg::item_type          it0_ff, it1_ff, it2_ff;
   logic [2:0][vn_pkg::SUM_W-1:0] sq_ff;
   logic [vn_pkg::SUM_W-1:0]  sum_ff;

   logic             [RW:0] vs_ff;
   vn_pkg::item_type        its_ff [RW+1];
   vn_pkg::sqrt_type        sq_st_ff [RW+1];
   vn_pkg::sqrt_type        sq_st_in [RW];

   logic             [QW:0] vd_ff;
   vn_pkg::item_type        itd_ff [QW+1];
   vn_pkg::div_type         dv_ff [QW+1];
   vn_pkg::div_type         dv_in [QW];

   vn_pkg::div_type         dvt_in;
   vn_pkg::item_type        it0_in;

   logic [2:0][FW-1:0]      res_in;
   logic [2:0][FW-1:0]      res_ff;
   logic [FW-1:0]           mag_ff;
   logic                    small_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_mag_ff <= vn_pkg::MIN_MAG_RESET;
      end else if (csr_valid && csr_ready) begin
         min_mag_ff <= csr_min_magnitude;
      end
   end

   always_comb begin
      it0_in.raw[0] = req_in_x;
      it0_in.raw[1] = req_in_y;
      it0_in.raw[2] = req_in_z;
      for (int i = 0; i < 3; i++) begin
         it0_in.mag_abs[i] = it0_in.raw[i][FW-1] ? FW'(-it0_in.raw[i]) : it0_in.raw[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      it0_ff <= it0_in;
      it1_ff <= it0_ff;
      it2_ff <= it1_ff;
      for (int i = 0; i < 3; i++) begin
         sq_ff[i] <= it0_ff.mag_abs[i] * it0_ff.mag_abs[i];
      end
      sum_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   // root chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff <= '0;
      end else begin
         vs_ff <= {vs_ff[RW-1:0], v2_ff};
      end
   end

   always_ff @(posedge clock) begin
      its_ff[0]        <= it2_ff;
      sq_st_ff[0].n    <= sum_ff;
      sq_st_ff[0].rem  <= '0;
      sq_st_ff[0].root <= '0;
      for (int k = 0; k < RW; k++) begin
         sq_st_ff[k+1] <= sq_st_in[k];
         its_ff[k+1]   <= its_ff[k];
      end
   end

   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      vn_sqrt_step u_step (
         .s_in  (sq_st_ff[k]),
         .s_out (sq_st_in[k])
      );
   end

   // compare and divider setup
   always_comb begin
      dvt_in.mag       = sq_st_ff[RW].root;
      dvt_in.too_small = sq_st_ff[RW].root < min_mag_ff;
      for (int i = 0; i < 3; i++) begin
         dvt_in.rem[i] = vn_pkg::DREM_W'(its_ff[RW].mag_abs[i]);
         dvt_in.quo[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= '0;
      end else begin
         vd_ff <= {vd_ff[QW-1:0], vs_ff[RW]};
      end
   end

   always_ff @(posedge clock) begin
      itd_ff[0] <= its_ff[RW];
      dv_ff[0]  <= dvt_in;
      for (int k = 0; k < QW; k++) begin
         dv_ff[k+1]  <= dv_in[k];
         itd_ff[k+1] <= itd_ff[k];
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_div
      vn_div_step u_step (
         .d_in  (dv_ff[k]),
         .d_out (dv_in[k])
      );
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dv_ff[QW].too_small) begin
            res_in[i] = itd_ff[QW].raw[i];
         end else if (dv_ff[QW].mag == '0) begin
            res_in[i] = '0;
         end else if (itd_ff[QW].raw[i][FW-1]) begin
            res_in[i] = -FW'(dv_ff[QW].quo[i]);
         end else begin
            res_in[i] = FW'(dv_ff[QW].quo[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else begin
         vo_ff <= vd_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      res_ff   <= res_in;
      mag_ff   <= dv_ff[QW].mag;
      small_ff <= dv_ff[QW].too_small;
   end

   assign rsp_valid     = vo_ff;
   assign rsp_out_x     = res_ff[0];
   assign rsp_out_y     = res_ff[1];
   assign rsp_out_z     = res_ff[2];
   assign rsp_magnitude = mag_ff;
   assign rsp_too_small = small_ff;
endmodule
`default_nettype wire

// ----- hdl/vn_checker.sv -----
// Port-level checks for the vector normalizer, bound to the top level.
// Uses vn_pkg and vector3_normalize_top_assert.svh.
`default_nettype none
`include "vector3_normalize_top_assert.svh"
module vn_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                busy,
   input wire                                csr_ready,
   input wire                                rsp_valid,
   input wire signed [vn_pkg::FIELD_W-1:0]   rsp_out_x,
   input wire signed [vn_pkg::FIELD_W-1:0]   rsp_out_y,
   input wire signed [vn_pkg::FIELD_W-1:0]   rsp_out_z,
   input wire        [vn_pkg::FIELD_W-1:0]   rsp_magnitude,
   input wire                                rsp_too_small
);
   localparam logic signed [vn_pkg::FIELD_W-1:0] UNIT = vn_pkg::FIELD_W'(1 << vn_pkg::FRAC_BITS);

   logic norm_word;
   logic zero_out;
   logic x_in_range;
   logic yz_in_range;

   assign norm_word   = rsp_valid && !rsp_too_small;
   assign zero_out    = rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0;
   assign x_in_range  = rsp_out_x <= UNIT && rsp_out_x >= -UNIT;
   assign yz_in_range = rsp_out_y <= UNIT && rsp_out_y >= -UNIT &&
                        rsp_out_z <= UNIT && rsp_out_z >= -UNIT;

   `VN_ASSERT_ALWAYS(a_never_busy, !busy && csr_ready)
   `VN_ASSERT_IMPLY(a_zero_mag, norm_word && rsp_magnitude == '0, zero_out)
   `VN_ASSERT_IMPLY(a_unit_x, norm_word, x_in_range)
   `VN_ASSERT_IMPLY(a_unit_yz, norm_word, yz_in_range)
endmodule

bind vector3_normalize_top vn_checker u_vn_checker (
   .clock         (clock),
   .reset         (reset),
   .busy          (busy),
   .csr_ready     (csr_ready),
   .rsp_valid     (rsp_valid),
   .rsp_out_x     (rsp_out_x),
   .rsp_out_y     (rsp_out_y),
   .rsp_out_z     (rsp_out_z),
   .rsp_magnitude (rsp_magnitude),
   .rsp_too_small (rsp_too_small)
);
`default_nettype wire
